@@ hw/rtl/glob_wildcard_match_unit_macros.svh @@
// Assertion macros for the glob wildcard match unit.
// With SYNTH defined, every macro expands to nothing.
`ifndef GLOB_WILDCARD_MATCH_UNIT_MACROS_SVH
`define GLOB_WILDCARD_MATCH_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define GLOB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glob_wildcard_match_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GLOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glob_wildcard_match_unit: next-cycle check failed");

`else

`define GLOB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GLOB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/glob_pkg.sv @@
package glob_pkg;

	// Default number of pattern positions.
	localparam int PATTERN_MAX_DEF = 16;

	// Widths fixed by the register map and the word fields.
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	// Pattern bytes with a special meaning.
	localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
	localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO  = 2'd0,
		CFG_PAT_HI  = 2'd1,
		CFG_PAT_LEN = 2'd2
	} cfg_reg_t;

	// Step control broadcast from the top level to every cell.
	typedef struct packed {
		logic take;     // a word is accepted this cycle
		logic present;  // the word carries a name byte
		logic fresh;    // the word is the first of a name
	} step_ctrl_t;

endpackage

@@ hw/rtl/glob_if.sv @@
// Name byte channel.
interface glob_name_if;
	logic                      valid;
	logic                      ready;
	logic [glob_pkg::CHAR_W-1:0] name_byte;
	logic                      byte_present;
	logic                      name_end;

	modport source (output valid, output name_byte, output byte_present,
		output name_end, input ready);
	modport sink (input valid, input name_byte, input byte_present,
		input name_end, output ready);
endinterface

// Match result channel.
interface glob_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

// Configuration write channel.
interface glob_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [glob_pkg::CFG_IDX_W-1:0]  index;
	logic [glob_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/glob_cell.sv @@
// One pattern position: holds its live bit, applies its pattern byte to the
// incoming name byte and passes star closure and advance terms to the right.
module glob_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  glob_pkg::step_ctrl_t        ctrl,
	input  logic                        seed,
	input  logic                        keep,
	input  logic                        act,
	input  logic [glob_pkg::CHAR_W-1:0] pat_char,
	input  logic [glob_pkg::CHAR_W-1:0] name_char,
	input  logic                        c1_prev,
	input  logic                        c2_prev,
	input  logic                        step_prev,
	output logic                        c1_next,
	output logic                        c2_next,
	output logic                        step_next,
	output logic                        live_next
);

	logic live_q;
	logic is_star;
	logic char_hit;
	logic pre;
	logic c1;
	logic nxt;
	logic c2;

	// Decode the pattern byte.
	assign is_star  = (pat_char == glob_pkg::STAR_CHAR);
	assign char_hit = (pat_char == glob_pkg::ANY_CHAR) || (pat_char == name_char);

	// Starting bit, trimmed to the current pattern length, then closed over stars.
	assign pre = keep & (ctrl.fresh ? seed : live_q);
	assign c1  = pre | c1_prev;
	assign c1_next = c1 & is_star & act;

	// Advance by one name byte: a star keeps its position, a hit moves right.
	assign step_next = c1 & act & ~is_star & char_hit;
	assign nxt       = c1_next | step_prev;
	assign c2        = nxt | c2_prev;
	assign c2_next   = c2 & is_star & act;

	assign live_next = ctrl.present ? c2 : c1;

	// Live bit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctrl.take) begin
			live_q <= live_next;
		end
	end

endmodule

@@ hw/rtl/glob_wildcard_match_unit.sv @@
// Timing: the result of a name's final word is offered on the result channel
// in the next cycle, from an output register.
// Throughput: one name word per cycle unless a held result is stalled; a row
// of cells updates the live set through two star-closure carry chains.
// Reset: arst_n clears the pattern registers, the live set and the output valid.
`include "glob_wildcard_match_unit_macros.svh"

module glob_wildcard_match_unit #(
	parameter int PATTERN_MAX = glob_pkg::PATTERN_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	glob_cfg_if.sink      cfg,
	glob_name_if.sink     name_ch,
	glob_result_if.source result_ch
);

	localparam int LEN_W  = glob_pkg::LEN_W;
	localparam int CHAR_W = glob_pkg::CHAR_W;
	localparam int NPOS   = PATTERN_MAX + 1;

	logic [glob_pkg::CFG_DATA_W-1:0] pat_lo_q;
	logic [glob_pkg::CFG_DATA_W-1:0] pat_hi_q;
	logic [LEN_W-1:0]                len_q;
	logic                            inside_q;
	logic                            ovalid_q;
	logic                            matched_q;

	logic [2*glob_pkg::CFG_DATA_W-1:0] pat_all;
	logic [LEN_W-1:0]                  eff_len;
	logic                              in_acc;
	glob_pkg::step_ctrl_t              ctrl;

	logic [NPOS-1:0] keep;
	logic [NPOS-1:0] act;
	logic [NPOS-1:0] sel;
	logic [NPOS-1:0] live_next;
	logic [NPOS:0]   c1_chain;
	logic [NPOS:0]   c2_chain;
	logic [NPOS:0]   step_chain;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
		end else if (cfg.valid) begin
			unique case (glob_pkg::cfg_reg_t'(cfg.index))
				glob_pkg::CFG_PAT_LO:  pat_lo_q <= cfg.data;
				glob_pkg::CFG_PAT_HI:  pat_hi_q <= cfg.data;
				glob_pkg::CFG_PAT_LEN: len_q    <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective pattern length, clipped to PATTERN_MAX.
	assign pat_all = {pat_hi_q, pat_lo_q};
	assign eff_len = (len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_q;

	// A word is taken whenever the output register is free or being emptied.
	assign name_ch.ready = !ovalid_q || result_ch.ready;
	assign in_acc        = name_ch.valid && name_ch.ready;

	assign ctrl.take    = in_acc;
	assign ctrl.present = name_ch.byte_present;
	assign ctrl.fresh   = !inside_q;

	assign c1_chain[0]   = 1'b0;
	assign c2_chain[0]   = 1'b0;
	assign step_chain[0] = 1'b0;

	// Row of cells, one per live position; the last one has no pattern byte.
	for (genvar i = 0; i < NPOS; i++) begin : g_cell
		logic [CHAR_W-1:0] pat_char;

		if (i < PATTERN_MAX) begin : g_byte
			assign pat_char = pat_all[i*CHAR_W +: CHAR_W];
		end else begin : g_end
			assign pat_char = '0;
		end

		assign keep[i] = (LEN_W'(i) <= eff_len);
		assign act[i]  = (LEN_W'(i) < eff_len);
		assign sel[i]  = (LEN_W'(i) == eff_len);

		glob_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.seed      (i == 0),
			.keep      (keep[i]),
			.act       (act[i]),
			.pat_char  (pat_char),
			.name_char (name_ch.name_byte),
			.c1_prev   (c1_chain[i]),
			.c2_prev   (c2_chain[i]),
			.step_prev (step_chain[i]),
			.c1_next   (c1_chain[i+1]),
			.c2_next   (c2_chain[i+1]),
			.step_next (step_chain[i+1]),
			.live_next (live_next[i])
		);
	end

	// Name tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (in_acc) begin
			inside_q <= !name_ch.name_end;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (in_acc && name_ch.name_end) begin
			ovalid_q <= 1'b1;
		end else if (result_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Result: the live bit at the end of the pattern.
	always_ff @(posedge clk) begin
		if (in_acc && name_ch.name_end) begin
			matched_q <= |(live_next & sel);
		end
	end

	assign result_ch.valid   = ovalid_q;
	assign result_ch.matched = matched_q;

	// A final word always produces a result in the next cycle.
	`GLOB_ASSERT_NEXT(a_end_gives_result, clk, arst_n, in_acc && name_ch.name_end, result_ch.valid)
	// A stalled result blocks further name words.
	`GLOB_ASSERT_SAME(a_stall_blocks, clk, arst_n, ovalid_q && !result_ch.ready, !name_ch.ready)
	// After a final word the next name starts from a fresh live set.
	`GLOB_ASSERT_NEXT(a_end_restarts, clk, arst_n, in_acc && name_ch.name_end, !inside_q)

endmodule

@@ tb/sv/glob_wildcard_match_unit_tb.sv @@
`timescale 1ns / 1ps

module glob_wildcard_match_unit_tb;

	localparam int PATTERN_MAX  = glob_pkg::PATTERN_MAX_DEF;
	localparam int CHAR_W       = glob_pkg::CHAR_W;
	localparam int LEN_W        = glob_pkg::LEN_W;
	localparam int CFG_DATA_W   = glob_pkg::CFG_DATA_W;
	localparam logic [CHAR_W-1:0] STAR_CHAR = glob_pkg::STAR_CHAR;
	localparam logic [CHAR_W-1:0] ANY_CHAR  = glob_pkg::ANY_CHAR;
	localparam int RANDOM_WORDS = 520;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	// Receiver stall behaviours, changed at random intervals.
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_BURSTY
	} sink_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	glob_cfg_if    cfg_if ();
	glob_name_if   name_if ();
	glob_result_if res_if ();

	glob_wildcard_match_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_if),
		.name_ch   (name_if),
		.result_ch (res_if)
	);

	// Predictor state: the pattern registers, the live position set and the
	// flag that says a name has been started.
	logic [CFG_DATA_W-1:0] pat_lo      = '0;
	logic [CFG_DATA_W-1:0] pat_hi      = '0;
	logic [LEN_W-1:0]      pat_len     = '0;
	logic [PATTERN_MAX:0]  live_set    = '0;
	logic                  in_name     = 1'b0;

	logic                  pending_verdicts[$];
	logic [CHAR_W-1:0]     name_bytes[$];
	logic                  due_verdict;

	int         burst_left      = 0;
	int         words_sent      = 0;
	int         names_closed    = 0;
	int         verdicts_seen   = 0;
	int         reg_writes      = 0;
	int         error_count     = 0;
	int         cycle_count     = 0;
	int         mode_left       = 0;
	sink_mode_t sink_mode       = SINK_OPEN;

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("glob_wildcard_match_unit_tb: done, errors");
			$finish;
		end
	end

	// The result side stalls on its own pattern, which changes mode now and then.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 80);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (sink_mode)
			SINK_OPEN:   res_if.ready <= 1'b1;
			SINK_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
			SINK_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
			default:     res_if.ready <= (cycle_count[3:0] >= 4'd12);
		endcase
	end

	// Every accepted result is compared with the oldest verdict waiting.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("matched: expected nothing, got %0b", res_if.matched);
				error_count++;
			end else begin
				due_verdict = pending_verdicts.pop_front();
				verdicts_seen++;
				if (res_if.matched !== due_verdict) begin
					$error("matched: expected %0b, got %0b", due_verdict, res_if.matched);
					error_count++;
				end
			end
		end
	end

	function automatic logic [CHAR_W-1:0] pattern_byte(int i);
		if (i < 8)
			return pat_lo[8*i +: 8];
		return pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic int active_length();
		return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
	endfunction

	// A live star also makes the position after it live; positions past the
	// pattern end are dropped.
	function automatic logic [PATTERN_MAX:0] close_over_stars(logic [PATTERN_MAX:0] set,
			int n);
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i < n && set[i] && pattern_byte(i) == STAR_CHAR)
				set[i+1] = 1'b1;
		end
		for (int i = 0; i <= PATTERN_MAX; i++) begin
			if (i > n)
				set[i] = 1'b0;
		end
		return set;
	endfunction

	// One name byte moves every live position on by the rule of its pattern byte.
	function automatic logic [PATTERN_MAX:0] consume_name_byte(logic [PATTERN_MAX:0] set,
			logic [CHAR_W-1:0] c, int n);
		logic [PATTERN_MAX:0] next;
		logic [CHAR_W-1:0]    p;
		next = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i < n && set[i]) begin
				p = pattern_byte(i);
				if (p == STAR_CHAR)
					next[i] = 1'b1;
				else if (p == ANY_CHAR || p == c)
					next[i+1] = 1'b1;
			end
		end
		return close_over_stars(next, n);
	endfunction

	// Updates the predictor for one accepted name word and queues the verdict
	// when the word closes a name.
	function automatic void predict_name_word(logic [CHAR_W-1:0] c, logic present,
			logic last);
		int n;
		n = active_length();
		if (!in_name)
			live_set = {{PATTERN_MAX{1'b0}}, 1'b1};
		live_set = close_over_stars(live_set, n);
		if (present)
			live_set = consume_name_byte(live_set, c, n);
		if (last) begin
			pending_verdicts.push_back(live_set[n]);
			in_name = 1'b0;
		end else begin
			in_name = 1'b1;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] pick_name_byte();
		if ($urandom_range(0, 3) == 0)
			return CHAR_W'($urandom_range(0, 255));
		return CHAR_W'("a" + $urandom_range(0, 2));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_pattern_byte();
		int r;
		r = $urandom_range(0, 15);
		if (r < 4)
			return STAR_CHAR;
		if (r < 7)
			return ANY_CHAR;
		if (r < 14)
			return CHAR_W'("a" + $urandom_range(0, 2));
		if (r == 14)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// Sends one name word; the sender works in bursts with gaps between them.
	task automatic send_name_word(logic [CHAR_W-1:0] c, logic present, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				name_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		name_if.valid        <= 1'b1;
		name_if.name_byte    <= c;
		name_if.byte_present <= present;
		name_if.name_end     <= last;
		@(posedge clk);
		while (!name_if.ready) @(posedge clk);
		predict_name_word(c, present, last);
		words_sent++;
		if (last)
			names_closed++;
	endtask

	// Writes one register and mirrors it into the predictor.
	task automatic write_register(glob_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			glob_pkg::CFG_PAT_LO:  pat_lo = value;
			glob_pkg::CFG_PAT_HI:  pat_hi = value;
			glob_pkg::CFG_PAT_LEN: pat_len = value[LEN_W-1:0];
			default:     ;
		endcase
		reg_writes++;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Lets the block drain before the pattern is touched.
	task automatic settle_idle();
		name_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_pattern(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
			logic [LEN_W-1:0] len);
		settle_idle();
		write_register(glob_pkg::CFG_PAT_LO, lo);
		write_register(glob_pkg::CFG_PAT_HI, hi);
		write_register(glob_pkg::CFG_PAT_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
	endtask

	// Sends name_bytes as one name, with the odd absent-byte word mixed in.
	// With close low the name is left open for the next phase.
	task automatic send_name(logic close);
		logic last;
		logic trailing;
		if (name_bytes.size() == 0) begin
			send_name_word(CHAR_W'($urandom_range(0, 255)), 1'b0, close);
			return;
		end
		foreach (name_bytes[i]) begin
			if ($urandom_range(0, 11) == 0)
				send_name_word(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
			last     = close && (i == name_bytes.size() - 1);
			trailing = last && ($urandom_range(0, 7) == 0);
			send_name_word(name_bytes[i], 1'b1, last && !trailing);
			if (trailing)
				send_name_word(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	// Mostly names built to fit the current pattern, some of them spoilt by
	// one edit, and some plain noise.
	task automatic build_name(int n);
		logic [CHAR_W-1:0] p;
		int                r;
		name_bytes.delete();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(0, 5))
				name_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
			return;
		end
		for (int i = 0; i < n; i++) begin
			p = pattern_byte(i);
			if (p == STAR_CHAR) begin
				repeat ($urandom_range(0, 3))
					name_bytes.push_back(pick_name_byte());
			end else if (p == ANY_CHAR) begin
				name_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
			end else begin
				name_bytes.push_back(p);
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			r = $urandom_range(0, 2);
			if (r == 0 || name_bytes.size() == 0)
				name_bytes.push_back(pick_name_byte());
			else if (r == 1)
				name_bytes.delete($urandom_range(0, name_bytes.size() - 1));
			else
				name_bytes[$urandom_range(0, name_bytes.size() - 1)] = pick_name_byte();
		end
	endtask

	// After reset the pattern is empty, so only the empty name matches.
	task automatic test_reset_pattern();
		send_name_word(8'h00, 1'b0, 1'b1);
		send_name_word(8'h00, 1'b1, 1'b1);
	endtask

	// Literal bytes, including zero and all-ones, and a single-byte wildcard.
	task automatic test_literals_and_any();
		program_pattern({32'h0, 8'hFF, 8'h00, ANY_CHAR, "a"}, '0, 5'd4);
		send_name_word("a", 1'b1, 1'b0);
		send_name_word(8'hFF, 1'b1, 1'b0);
		send_name_word(8'h00, 1'b1, 1'b0);
		send_name_word(8'hFF, 1'b1, 1'b1);
		// Upper case must not match a lower-case pattern byte.
		send_name_word("A", 1'b1, 1'b0);
		send_name_word("x", 1'b1, 1'b0);
		send_name_word(8'h00, 1'b1, 1'b0);
		send_name_word(8'hFF, 1'b1, 1'b1);
	endtask

	// A trailing star, an absent byte in the middle of a name and an empty name.
	task automatic test_star_and_absent();
		program_pattern({48'h0, STAR_CHAR, "x"}, '0, 5'd2);
		send_name_word("x", 1'b1, 1'b0);
		send_name_word(8'hFF, 1'b0, 1'b0);
		send_name_word("y", 1'b1, 1'b1);
		send_name_word("x", 1'b0, 1'b1);
	endtask

	// A length past the maximum is clipped, so byte 15 still counts.
	task automatic test_overlong_length();
		program_pattern({8{STAR_CHAR}}, {"z", {7{STAR_CHAR}}}, 5'd31);
		send_name_word("z", 1'b1, 1'b1);
		send_name_word("q", 1'b1, 1'b1);
	endtask

	// Shortening the pattern part-way through a name acts on the live set at once.
	task automatic test_pattern_change_mid_name();
		program_pattern({48'h0, "b", "a"}, '0, 5'd2);
		send_name_word("a", 1'b1, 1'b0);
		settle_idle();
		write_register(glob_pkg::CFG_PAT_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, 5'd1});
		send_name_word(8'h00, 1'b0, 1'b1);
	endtask

	// Random patterns, lengths from empty to overlong, each followed by a batch
	// of names; now and then a name is left open across a pattern change.
	task automatic test_random_names();
		int                    target;
		int                    n;
		int                    start;
		logic [LEN_W-1:0]      len;
		logic [CHAR_W-1:0]     p;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_DATA_W-1:0] len_word;
		glob_pkg::cfg_reg_t    order[3];
		order  = '{glob_pkg::CFG_PAT_LO, glob_pkg::CFG_PAT_HI, glob_pkg::CFG_PAT_LEN};
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			case ($urandom_range(0, 9))
				0:       len = 5'd0;
				1:       len = 5'd16;
				2:       len = LEN_W'($urandom_range(17, 31));
				default: len = LEN_W'($urandom_range(1, 8));
			endcase
			n = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
			for (int i = 0; i < PATTERN_MAX; i++) begin
				p = (i < n) ? pick_pattern_byte() : CHAR_W'($urandom_range(0, 255));
				if (i < 8)
					lo[8*i +: 8] = p;
				else
					hi[8*(i-8) +: 8] = p;
			end
			len_word        = {$urandom(), $urandom()};
			len_word[LEN_W-1:0] = len;
			settle_idle();
			start = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) begin
				case (order[(start + k) % 3])
					glob_pkg::CFG_PAT_LO:  write_register(glob_pkg::CFG_PAT_LO, lo);
					glob_pkg::CFG_PAT_HI:  write_register(glob_pkg::CFG_PAT_HI, hi);
					default:     write_register(glob_pkg::CFG_PAT_LEN, len_word);
				endcase
			end
			repeat ($urandom_range(3, 10)) begin
				build_name(n);
				send_name(1'b1);
			end
			if ($urandom_range(0, 5) == 0) begin
				build_name(n);
				send_name(1'b0);
			end
		end
		settle_idle();
	endtask

	initial begin
		name_if.valid        = 1'b0;
		name_if.name_byte    = '0;
		name_if.byte_present = 1'b0;
		name_if.name_end     = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = glob_pkg::CFG_PAT_LO;
		cfg_if.data          = '0;
		res_if.ready         = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pattern();
		test_literals_and_any();
		test_star_and_absent();
		test_overlong_length();
		test_pattern_change_mid_name();
		test_random_names();

		// Drain whatever is still owed, then give stray results time to show.
		name_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d name words closing %0d names; %0d verdicts compared, %0d writes.",
			words_sent, names_closed, verdicts_seen, reg_writes);
		$display("Patterns ran from empty to overlong lengths with stars, wildcards and literals.");
		if (error_count == 0) begin
			$display("glob_wildcard_match_unit_tb: done, clean");
		end else begin
			$display("glob_wildcard_match_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
